@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the bounded event stack.
// Define NO_ASSERTIONS to compile every check out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle as ante.
`define BES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define BES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BES_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BES_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/bes_pkg.sv @@
// Shared types and constants for the bounded event stack.
// No dependencies; used by bes_mem, bes_ctrl and bounded_event_stack_top.
package bes_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int EVENT_BITS_DEFAULT = 64;
    localparam int WORD_W             = 64;
    localparam int ACTION_W           = 2;
    localparam int LIMIT_W            = 5;
    localparam int COUNT_OUT_W        = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } seq_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

@@ rtl/bes_mem.sv @@
// Entry storage for the bounded event stack: one write port, one registered read port.
// Depends on bes_pkg for the memory control struct.
module bes_mem #(
    parameter int DEPTH      = bes_pkg::DEPTH_DEFAULT,
    parameter int EVENT_BITS = bes_pkg::EVENT_BITS_DEFAULT
) (
    input  logic                     clk,
    input  bes_pkg::mem_ctl_t        ctl,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [EVENT_BITS-1:0]    wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [EVENT_BITS-1:0]    rd_data
);

    logic [EVENT_BITS-1:0] entry_mem [DEPTH];
    logic [EVENT_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bes_ctrl.sv @@
// Sequencer, pointer unit and result register of the bounded event stack.
// Depends on bes_pkg; drives bes_mem through a bes_pkg::mem_ctl_t struct.
module bes_ctrl #(
    parameter int DEPTH      = bes_pkg::DEPTH_DEFAULT,
    parameter int EVENT_BITS = bes_pkg::EVENT_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bes_pkg::LIMIT_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bes_pkg::ACTION_W-1:0]    action,
    input  logic [bes_pkg::WORD_W-1:0]      event_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bes_pkg::WORD_W-1:0]      result_word,
    output logic                            has_entry,
    output logic [bes_pkg::COUNT_OUT_W-1:0] stored_count,
    output logic                            now_empty,
    output logic                            last_of_run,
    output bes_pkg::mem_ctl_t               mem_ctl,
    output logic [$clog2(DEPTH)-1:0]        mem_wr_addr,
    output logic [EVENT_BITS-1:0]           mem_wr_data,
    output logic [$clog2(DEPTH)-1:0]        mem_rd_addr,
    input  logic [EVENT_BITS-1:0]           mem_rd_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_LAST : idx - IDX_W'(1);
    endfunction

    bes_pkg::seq_state_t state_reg, state_next;

    logic [bes_pkg::LIMIT_W-1:0] max_entries_reg;
    logic [IDX_W-1:0]            top_reg, top_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]            remain_reg, remain_next;
    logic                        carry_reg, carry_next;

    logic                             out_valid_reg, out_valid_next;
    logic [bes_pkg::WORD_W-1:0]       out_word_reg, out_word_next;
    logic                             out_has_reg, out_has_next;
    logic [bes_pkg::COUNT_OUT_W-1:0]  out_count_reg, out_count_next;
    logic                             out_empty_reg, out_empty_next;
    logic                             out_last_reg, out_last_next;

    logic             in_xfer;
    logic             out_free;
    logic             out_load;
    logic             run_more;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] count_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != bes_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == bes_pkg::ST_SEND) && out_free;
    assign run_more  = carry_reg && (remain_reg != CNT_W'(1));

    always_comb
    begin
        if (max_entries_reg == '0 || 32'(max_entries_reg) > 32'(DEPTH))
        begin
            limit = CNT_FULL;
        end
        else
        begin
            limit = CNT_W'(max_entries_reg);
        end
    end

    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bes_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if ((action == bes_pkg::ACT_POP || action == bes_pkg::ACT_DUMP)
                        && count_reg != '0)
                    begin
                        state_next = bes_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = bes_pkg::ST_SEND;
                    end
                end
            end
            bes_pkg::ST_READ:
            begin
                state_next = bes_pkg::ST_SEND;
            end
            bes_pkg::ST_SEND:
            begin
                if (out_free)
                begin
                    state_next = run_more ? bes_pkg::ST_READ : bes_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bes_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        top_next       = top_reg;
        count_next     = count_reg;
        rd_addr_next   = rd_addr_reg;
        remain_next    = remain_reg;
        carry_next     = carry_reg;
        mem_ctl        = '0;
        mem_wr_addr    = idx_inc(top_reg);
        mem_wr_data    = event_word[EVENT_BITS-1:0];
        mem_rd_addr    = rd_addr_reg;
        out_word_next  = out_word_reg;
        out_has_next   = out_has_reg;
        out_count_next = out_count_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            bes_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    carry_next = 1'b0;
                    case (action)
                        bes_pkg::ACT_PUSH:
                        begin
                            mem_ctl.wr_en = 1'b1;
                            top_next      = idx_inc(top_reg);
                            count_next    = (count_inc > limit) ? count_reg : count_inc;
                        end
                        bes_pkg::ACT_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_addr_next = top_reg;
                                top_next     = idx_dec(top_reg);
                                count_next   = count_reg - CNT_W'(1);
                                remain_next  = CNT_W'(1);
                                carry_next   = 1'b1;
                            end
                        end
                        bes_pkg::ACT_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_addr_next = top_reg;
                                remain_next  = count_reg;
                                carry_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            carry_next = 1'b0;
                        end
                    endcase
                end
            end
            bes_pkg::ST_READ:
            begin
                mem_ctl.rd_en = 1'b1;
            end
            bes_pkg::ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = carry_reg ? bes_pkg::WORD_W'(mem_rd_data) : '0;
                    out_has_next   = carry_reg;
                    out_count_next = bes_pkg::COUNT_OUT_W'(count_reg);
                    out_empty_next = (count_reg == '0);
                    out_last_next  = !run_more;
                    if (run_more)
                    begin
                        remain_next  = remain_reg - CNT_W'(1);
                        rd_addr_next = idx_dec(rd_addr_reg);
                    end
                end
            end
            default:
            begin
                carry_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bes_pkg::ST_IDLE;
            max_entries_reg <= '0;
            top_reg         <= '0;
            count_reg       <= '0;
            carry_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            carry_reg     <= carry_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_entries_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        remain_reg    <= remain_next;
        out_word_reg  <= out_word_next;
        out_has_reg   <= out_has_next;
        out_count_reg <= out_count_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_word  = out_word_reg;
    assign has_entry    = out_has_reg;
    assign stored_count = out_count_reg;
    assign now_empty    = out_empty_reg;
    assign last_of_run  = out_last_reg;

endmodule

@@ rtl/bounded_event_stack_top.sv @@
// Top level of the bounded event stack: sequencer plus entry storage.
// Depends on bes_pkg, bes_mem, bes_ctrl and assert_macros.svh.
//
// LIFO of event words held in a circular buffer of DEPTH entries; a push past the
// limit in max_entries (0 or above DEPTH means DEPTH) drops the oldest entry.
// One item is in work at a time. A push, an empty pop or dump, or an unused
// action code passes only the send state; a pop with an entry passes read, then
// send; a dump passes read and send once per entry. The single registered read
// port of the entry memory and the sequencer pacing each result through the
// output register set these steps; output stalls hold the send state. The
// result register frees the input side as soon as the last result is loaded.
`include "assert_macros.svh"

module bounded_event_stack_top #(
    parameter int DEPTH      = bes_pkg::DEPTH_DEFAULT,
    parameter int EVENT_BITS = bes_pkg::EVENT_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bes_pkg::LIMIT_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bes_pkg::ACTION_W-1:0]    action,
    input  logic [bes_pkg::WORD_W-1:0]      event_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bes_pkg::WORD_W-1:0]      result_word,
    output logic                            has_entry,
    output logic [bes_pkg::COUNT_OUT_W-1:0] stored_count,
    output logic                            now_empty,
    output logic                            last_of_run
);

    bes_pkg::mem_ctl_t           mem_ctl;
    logic [$clog2(DEPTH)-1:0]    mem_wr_addr;
    logic [EVENT_BITS-1:0]       mem_wr_data;
    logic [$clog2(DEPTH)-1:0]    mem_rd_addr;
    logic [EVENT_BITS-1:0]       mem_rd_data;

    bes_ctrl #(
        .DEPTH      (DEPTH),
        .EVENT_BITS (EVENT_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .event_word   (event_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_word  (result_word),
        .has_entry    (has_entry),
        .stored_count (stored_count),
        .now_empty    (now_empty),
        .last_of_run  (last_of_run),
        .mem_ctl      (mem_ctl),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    bes_mem #(
        .DEPTH      (DEPTH),
        .EVENT_BITS (EVENT_BITS)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    `BES_ASSERT_SAME(a_no_entry_zero_word, clk, rst_n, out_valid && !has_entry, result_word == '0)
    `BES_ASSERT_SAME(a_run_continues_with_entry, clk, rst_n, out_valid && !last_of_run, has_entry)
    `BES_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule
